// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/cpu4_pkg.sv =====
// ----------------------------------------------------------------------------
// cpu4_pkg
// Types and constants shared by the 4-bit core controller and datapath.
// ----------------------------------------------------------------------------
package cpu4_pkg;

    localparam int STACK_LEVELS = 3;

    // Request kinds carried on the input tuser bit.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EXEC = 1'b1;

    // Program memory address sources.
    localparam logic [1:0] ROM_SEL_PC   = 2'd0;
    localparam logic [1:0] ROM_SEL_NEXT = 2'd1;
    localparam logic [1:0] ROM_SEL_FIN  = 2'd2;
    localparam logic [1:0] ROM_SEL_LOAD = 2'd3;

    // Port write codes reported with each result.
    localparam logic [1:0] PW_NONE = 2'd0;
    localparam logic [1:0] PW_ROM  = 2'd1;
    localparam logic [1:0] PW_RAM  = 2'd2;

    typedef struct packed {
        logic       start;
        logic       load_wr;
        logic [1:0] rom_sel;
        logic       lat_op;
        logic       lat_b2;
        logic       lat_fin;
        logic       lat_ram;
        logic       commit;
    } cmd_t;

    typedef struct packed {
        logic clearing;
    } sts_t;

endpackage

// ===== design/cpu4_ram.sv =====
// ----------------------------------------------------------------------------
// cpu4_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module cpu4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we && ({1'b0, addr} < (AW+1)'(DEPTH)))
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== design/cpu4_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpu4_ctrl
// Sequencing state machine: handshakes, fetch order and commit.
// ----------------------------------------------------------------------------
module cpu4_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_kind,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  cpu4_pkg::sts_t  sts,
    output cpu4_pkg::cmd_t  cmd
);
    import cpu4_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_OP   = 3'd1;
    localparam logic [2:0] S_B2   = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_EXEC = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       valid_reg, valid_next;

    assign in_ready  = (state_reg == S_IDLE) && !sts.clearing;
    assign out_valid = valid_reg;

    always_comb
    begin
        cmd         = '0;
        cmd.rom_sel = ROM_SEL_PC;
        state_next  = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.start = 1'b1;
                    if (in_kind == OP_LOAD)
                    begin
                        cmd.load_wr = 1'b1;
                        cmd.rom_sel = ROM_SEL_LOAD;
                        state_next  = S_EXEC;
                    end
                    else
                    begin
                        state_next = S_OP;
                    end
                end
            end
            S_OP:
            begin
                cmd.lat_op  = 1'b1;
                cmd.rom_sel = ROM_SEL_NEXT;
                state_next  = S_B2;
            end
            S_B2:
            begin
                cmd.lat_b2  = 1'b1;
                cmd.rom_sel = ROM_SEL_FIN;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                cmd.lat_fin = 1'b1;
                cmd.lat_ram = 1'b1;
                state_next  = S_EXEC;
            end
            S_EXEC:
            begin
                if (!valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.commit)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end
endmodule

// ===== design/cpu4_dpath.sv =====
// ----------------------------------------------------------------------------
// cpu4_dpath
// Architectural registers, memories, ALU and the result register.
// ----------------------------------------------------------------------------
module cpu4_dpath #(
    parameter int ROM_DEPTH = 4096,
    parameter int RAM_BANKS = 8,
    parameter int ROM_PORTS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  cpu4_pkg::cmd_t cmd,
    output cpu4_pkg::sts_t sts,
    input  logic           in_kind,
    input  logic [11:0]    in_rom_address,
    input  logic [7:0]     in_rom_byte,
    input  logic           in_test_pin,
    output logic [11:0]    out_pc,
    output logic [3:0]     out_acc,
    output logic           out_carry,
    output logic [7:0]     out_byte,
    output logic [1:0]     out_pw,
    output logic [4:0]     out_psel,
    output logic [3:0]     out_pval
);
    import cpu4_pkg::*;

    localparam int ROM_AW     = $clog2(ROM_DEPTH);
    localparam int CHAR_DEPTH = RAM_BANKS * 256;
    localparam int STAT_DEPTH = RAM_BANKS * 64;
    localparam int CHAR_AW    = $clog2(CHAR_DEPTH);
    localparam int STAT_AW    = $clog2(STAT_DEPTH);
    localparam int BANK_W     = (RAM_BANKS > 1) ? $clog2(RAM_BANKS) : 1;
    localparam int PORT_W     = (ROM_PORTS > 1) ? $clog2(ROM_PORTS) : 1;
    localparam logic [1:0] SP_LAST = 2'(STACK_LEVELS - 1);

    // Architectural state.
    logic [11:0]       pc_reg, pc_next;
    logic [3:0]        acc_reg, acc_next;
    logic              carry_reg, carry_next;
    logic [3:0]        idx_reg [16];
    logic [3:0]        idx_next [16];
    logic [11:0]       stk_reg [STACK_LEVELS];
    logic [11:0]       stk_next [STACK_LEVELS];
    logic [1:0]        sp_reg, sp_next;
    logic [7:0]        src_reg, src_next;
    logic [BANK_W-1:0] bank_reg, bank_next;
    logic [3:0]        rport_reg [ROM_PORTS];
    logic [3:0]        rport_next [ROM_PORTS];

    // Per-request working registers.
    logic       load_reg;
    logic       test_reg;
    logic [7:0] op_reg, b2_reg, fin_reg;
    logic [3:0] char_q_reg, stat_q_reg;
    logic       rom_ok_reg;

    // RAM initialisation sweep.
    logic               clr_reg;
    logic [CHAR_AW-1:0] clr_cnt_reg;

    // Memory ports.
    logic [11:0]        prog_addr;
    logic               rom_ok;
    logic               rom_we;
    logic [7:0]         rom_rdata, rom_byte;
    logic [CHAR_AW-1:0] char_addr;
    logic [STAT_AW-1:0] stat_addr;
    logic               char_we, stat_we;
    logic [3:0]         char_wdata, stat_wdata;
    logic [3:0]         char_rdata, stat_rdata;

    // Result staging.
    logic [1:0] pw_next;
    logic [4:0] psel_next;
    logic [3:0] pval_next;

    logic [11:0] pc_inc1, pc_inc2;
    assign pc_inc1 = pc_reg + 12'd1;
    assign pc_inc2 = pc_reg + 12'd2;

    assign sts.clearing = clr_reg;

    always_comb
    begin
        case (cmd.rom_sel)
            ROM_SEL_PC:   prog_addr = pc_reg;
            ROM_SEL_NEXT: prog_addr = pc_inc1;
            ROM_SEL_FIN:  prog_addr = {pc_inc1[11:8], idx_reg[0], idx_reg[1]};
            default:      prog_addr = in_rom_address;
        endcase
    end

    assign rom_ok   = ({1'b0, prog_addr} < 13'(ROM_DEPTH));
    assign rom_we   = cmd.load_wr && rom_ok;
    assign rom_byte = rom_ok_reg ? rom_rdata : 8'd0;

    cpu4_ram #(.WIDTH(8), .DEPTH(ROM_DEPTH)) u_rom (
        .clk   (clk),
        .we    (rom_we),
        .addr  (prog_addr[ROM_AW-1:0]),
        .wdata (in_rom_byte),
        .rdata (rom_rdata)
    );

    assign char_addr  = clr_reg ? clr_cnt_reg : CHAR_AW'({bank_reg, src_reg});
    assign stat_addr  = clr_reg ? clr_cnt_reg[STAT_AW-1:0]
                                : STAT_AW'({bank_reg, src_reg[7:4], op_reg[1:0]});
    assign char_we    = clr_reg || (cmd.commit && !load_reg && op_reg == 8'hE0);
    assign stat_we    = clr_reg || (cmd.commit && !load_reg && op_reg[7:2] == 6'b111001);
    assign char_wdata = clr_reg ? 4'd0 : acc_reg;
    assign stat_wdata = clr_reg ? 4'd0 : acc_reg;

    cpu4_ram #(.WIDTH(4), .DEPTH(CHAR_DEPTH)) u_char (
        .clk   (clk),
        .we    (char_we),
        .addr  (char_addr),
        .wdata (char_wdata),
        .rdata (char_rdata)
    );

    cpu4_ram #(.WIDTH(4), .DEPTH(STAT_DEPTH)) u_stat (
        .clk   (clk),
        .we    (stat_we),
        .addr  (stat_addr),
        .wdata (stat_wdata),
        .rdata (stat_rdata)
    );

    // Instruction execution.
    always_comb
    begin
        logic [3:0]  hi, lo;
        logic [3:0]  idx_lo, pair_h, pair_l, inc;
        logic [4:0]  sum;
        logic        jmp;
        logic [1:0]  sp_dec;
        logic [3:0]  tport;
        logic        port_ok;
        logic [2:0]  bmod;

        hi       = op_reg[7:4];
        lo       = op_reg[3:0];
        idx_lo   = idx_reg[lo];
        pair_h   = idx_reg[{lo[3:1], 1'b0}];
        pair_l   = idx_reg[{lo[3:1], 1'b1}];
        inc      = idx_lo + 4'd1;
        sum      = '0;
        jmp      = 1'b0;
        sp_dec   = (sp_reg == 2'd0) ? SP_LAST : sp_reg - 2'd1;
        tport    = src_reg[7:4];
        port_ok  = ({1'b0, tport} < 5'(ROM_PORTS));
        bmod     = acc_reg[2:0];

        pc_next    = pc_inc1;
        acc_next   = acc_reg;
        carry_next = carry_reg;
        idx_next   = idx_reg;
        stk_next   = stk_reg;
        sp_next    = sp_reg;
        src_next   = src_reg;
        bank_next  = bank_reg;
        rport_next = rport_reg;
        pw_next    = PW_NONE;
        psel_next  = 5'd0;
        pval_next  = 4'd0;

        // Reduce the DCL value into the implemented bank range.
        for (int i = 0; i < 8; i++)
        begin
            if ({1'b0, bmod} >= 4'(RAM_BANKS))
            begin
                bmod = bmod - 3'(RAM_BANKS);
            end
        end

        case (hi)
            4'h1:
            begin
                jmp = (lo[2] && acc_reg == 4'd0) || (lo[1] && carry_reg)
                      || (lo[0] && !test_reg);
                if (lo[3])
                begin
                    jmp = !jmp;
                end
                pc_next = jmp ? {pc_inc2[11:8], b2_reg} : pc_inc2;
            end
            4'h2:
            begin
                if (!lo[0])
                begin
                    idx_next[{lo[3:1], 1'b0}] = b2_reg[7:4];
                    idx_next[{lo[3:1], 1'b1}] = b2_reg[3:0];
                    pc_next = pc_inc2;
                end
                else
                begin
                    src_next = {pair_h, pair_l};
                end
            end
            4'h3:
            begin
                if (!lo[0])
                begin
                    idx_next[{lo[3:1], 1'b0}] = fin_reg[7:4];
                    idx_next[{lo[3:1], 1'b1}] = fin_reg[3:0];
                end
                else
                begin
                    pc_next = {pc_inc1[11:8], pair_h, pair_l};
                end
            end
            4'h4: pc_next = {lo, b2_reg};
            4'h5:
            begin
                stk_next[sp_reg] = pc_inc2;
                sp_next = (sp_reg == SP_LAST) ? 2'd0 : sp_reg + 2'd1;
                pc_next = {lo, b2_reg};
            end
            4'h6: idx_next[lo] = inc;
            4'h7:
            begin
                idx_next[lo] = inc;
                pc_next = (inc != 4'd0) ? {pc_inc2[11:8], b2_reg} : pc_inc2;
            end
            4'h8:
            begin
                sum = {1'b0, acc_reg} + {1'b0, idx_lo} + {4'd0, carry_reg};
                acc_next = sum[3:0];
                carry_next = sum[4];
            end
            4'h9:
            begin
                sum = {1'b0, acc_reg} + {1'b0, ~idx_lo} + {4'd0, ~carry_reg};
                acc_next = sum[3:0];
                carry_next = sum[4];
            end
            4'hA: acc_next = idx_lo;
            4'hB:
            begin
                acc_next = idx_lo;
                idx_next[lo] = acc_reg;
            end
            4'hC:
            begin
                acc_next = lo;
                sp_next = sp_dec;
                pc_next = stk_reg[sp_dec];
            end
            4'hD: acc_next = lo;
            4'hE:
            begin
                case (lo)
                    4'h1:
                    begin
                        pw_next   = PW_RAM;
                        psel_next = {3'(bank_reg), src_reg[7:6]};
                        pval_next = acc_reg;
                    end
                    4'h2:
                    begin
                        if (port_ok)
                        begin
                            rport_next[tport[PORT_W-1:0]] = acc_reg;
                            pw_next   = PW_ROM;
                            psel_next = {1'b0, tport};
                            pval_next = acc_reg;
                        end
                    end
                    4'h8:
                    begin
                        sum = {1'b0, acc_reg} + {1'b0, ~char_q_reg} + {4'd0, ~carry_reg};
                        acc_next = sum[3:0];
                        carry_next = sum[4];
                    end
                    4'h9: acc_next = char_q_reg;
                    4'hA: acc_next = port_ok ? rport_reg[tport[PORT_W-1:0]] : 4'd0;
                    4'hB:
                    begin
                        sum = {1'b0, acc_reg} + {1'b0, char_q_reg} + {4'd0, carry_reg};
                        acc_next = sum[3:0];
                        carry_next = sum[4];
                    end
                    4'hC, 4'hD, 4'hE, 4'hF: acc_next = stat_q_reg;
                    default: ;
                endcase
            end
            4'hF:
            begin
                case (lo)
                    4'h0:
                    begin
                        acc_next = 4'd0;
                        carry_next = 1'b0;
                    end
                    4'h1: carry_next = 1'b0;
                    4'h2:
                    begin
                        sum = {1'b0, acc_reg} + 5'd1;
                        acc_next = sum[3:0];
                        carry_next = sum[4];
                    end
                    4'h3: carry_next = !carry_reg;
                    4'h4: acc_next = ~acc_reg;
                    4'h5:
                    begin
                        carry_next = acc_reg[3];
                        acc_next = {acc_reg[2:0], carry_reg};
                    end
                    4'h6:
                    begin
                        carry_next = acc_reg[0];
                        acc_next = {carry_reg, acc_reg[3:1]};
                    end
                    4'h7:
                    begin
                        acc_next = {3'd0, carry_reg};
                        carry_next = 1'b0;
                    end
                    4'h8:
                    begin
                        sum = {1'b0, acc_reg} + 5'd15;
                        acc_next = sum[3:0];
                        carry_next = sum[4];
                    end
                    4'h9:
                    begin
                        acc_next = carry_reg ? 4'd10 : 4'd9;
                        carry_next = 1'b0;
                    end
                    4'hA: carry_next = 1'b1;
                    4'hB:
                    begin
                        if (carry_reg || acc_reg > 4'd9)
                        begin
                            sum = {1'b0, acc_reg} + 5'd6;
                            acc_next = sum[3:0];
                            if (sum[4])
                            begin
                                carry_next = 1'b1;
                            end
                        end
                    end
                    4'hC:
                    begin
                        case (acc_reg)
                            4'd0, 4'd1, 4'd2: acc_next = acc_reg;
                            4'd4:             acc_next = 4'd3;
                            4'd8:             acc_next = 4'd4;
                            default:          acc_next = 4'd15;
                        endcase
                    end
                    4'hD: bank_next = bmod[BANK_W-1:0];
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // Control and architectural registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= '0;
            acc_reg     <= '0;
            carry_reg   <= 1'b0;
            sp_reg      <= '0;
            src_reg     <= '0;
            bank_reg    <= '0;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
            for (int i = 0; i < 16; i++)
            begin
                idx_reg[i] <= '0;
            end
            for (int i = 0; i < STACK_LEVELS; i++)
            begin
                stk_reg[i] <= '0;
            end
            for (int i = 0; i < ROM_PORTS; i++)
            begin
                rport_reg[i] <= '0;
            end
        end
        else
        begin
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CHAR_AW'(CHAR_DEPTH - 1))
                begin
                    clr_reg <= 1'b0;
                end
            end
            if (cmd.commit && !load_reg)
            begin
                pc_reg     <= pc_next;
                acc_reg    <= acc_next;
                carry_reg  <= carry_next;
                idx_reg    <= idx_next;
                stk_reg    <= stk_next;
                sp_reg     <= sp_next;
                src_reg    <= src_next;
                bank_reg   <= bank_next;
                rport_reg  <= rport_next;
            end
        end
    end

    // Working and result payload registers.
    always_ff @(posedge clk)
    begin
        rom_ok_reg <= rom_ok;
        if (cmd.start)
        begin
            load_reg <= (in_kind == OP_LOAD);
            test_reg <= in_test_pin;
        end
        if (cmd.lat_op)
        begin
            op_reg <= rom_byte;
        end
        if (cmd.lat_b2)
        begin
            b2_reg <= rom_byte;
        end
        if (cmd.lat_fin)
        begin
            fin_reg <= rom_byte;
        end
        if (cmd.lat_ram)
        begin
            char_q_reg <= char_rdata;
            stat_q_reg <= stat_rdata;
        end
        if (cmd.commit)
        begin
            if (load_reg)
            begin
                out_pc    <= pc_reg;
                out_acc   <= acc_reg;
                out_carry <= carry_reg;
                out_byte  <= 8'd0;
                out_pw    <= PW_NONE;
                out_psel  <= 5'd0;
                out_pval  <= 4'd0;
            end
            else
            begin
                out_pc    <= pc_next;
                out_acc   <= acc_next;
                out_carry <= carry_next;
                out_byte  <= op_reg;
                out_pw    <= pw_next;
                out_psel  <= psel_next;
                out_pval  <= pval_next;
            end
        end
    end
endmodule

// ===== design/four_bit_cpu_instruction_execute.sv =====
// ----------------------------------------------------------------------------
// four_bit_cpu_instruction_execute
// 4-bit CPU core: loads program memory bytes and executes one instruction
// per request, reporting pc, accumulator, carry and any port write.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                 Contents
// s_axis    in   s_axis_tvalid/tready      load or execute request
// m_axis    out  m_axis_tvalid/tready      one result per request
//
// A load request writes program memory on its accepting edge; its result is
// registered at commit, and the input reopens as that result becomes valid.
// An execute request walks opcode read, second byte read, then FIN byte and
// RAM reads side by side, then execution; its result is registered at commit
// and the next request is taken only after that commit. The registered memory
// reads set this order of steps.
// After reset the core sweeps RAM_BANKS*256 addresses clearing the character
// and status memories and accepts no request until that sweep ends.
// The result register frees the input side: a new request may be accepted
// while a result still waits, and commit stalls only if that slot is full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module four_bit_cpu_instruction_execute #(
    parameter int ROM_DEPTH = 4096,
    parameter int RAM_BANKS = 8,
    parameter int ROM_PORTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [11:0] rom_address, [19:12] rom_byte, [20] test_pin, [23:21] zero
    input  logic [23:0] s_axis_tdata,
    // [0] opcode
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [11:0] pc_after, [15:12] accumulator, [16] carry_flag,
    // [24:17] executed_byte, [26:25] port_write, [31:27] port_select,
    // [35:32] port_value, [39:36] zero
    output logic [39:0] m_axis_tdata
);
    import cpu4_pkg::*;

    cmd_t cmd;
    sts_t sts;

    logic [11:0] res_pc;
    logic [3:0]  res_acc;
    logic        res_carry;
    logic [7:0]  res_byte;
    logic [1:0]  res_pw;
    logic [4:0]  res_psel;
    logic [3:0]  res_pval;

    // The controller sequences each request; the datapath holds the architectural state and memories.
    cpu4_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_kind   (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    cpu4_dpath #(
        .ROM_DEPTH (ROM_DEPTH),
        .RAM_BANKS (RAM_BANKS),
        .ROM_PORTS (ROM_PORTS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .in_kind        (s_axis_tuser),
        .in_rom_address (s_axis_tdata[11:0]),
        .in_rom_byte    (s_axis_tdata[19:12]),
        .in_test_pin    (s_axis_tdata[20]),
        .out_pc         (res_pc),
        .out_acc        (res_acc),
        .out_carry      (res_carry),
        .out_byte       (res_byte),
        .out_pw         (res_pw),
        .out_psel       (res_psel),
        .out_pval       (res_pval)
    );

    assign m_axis_tdata = {4'd0, res_pval, res_psel, res_pw, res_byte,
                           res_carry, res_acc, res_pc};

    // No request is taken while the RAM clearing sweep is running.
    `ASSERT_IMPLY(a_no_accept_clearing, clk, rst_n, sts.clearing, !s_axis_tready)
    // Only one request is in flight: the input is closed in the cycle after an acceptance.
    `ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // A commit never lands on a full result slot that is not being drained.
    `ASSERT_IMPLY(a_commit_slot, clk, rst_n, cmd.commit, !m_axis_tvalid || m_axis_tready)
    // The port write code is never the unused value.
    `ASSERT_IMPLY(a_pw_code, clk, rst_n, m_axis_tvalid, m_axis_tdata[26:25] != 2'd3)
endmodule
